// File: sv/rrs_pkg.sv
`timescale 1ns / 1ps

package rrs_pkg;

    // default sizes for the top level parameters
    localparam int MAX_PROCESSES_DEF = 64;
    localparam int MAX_CPUS_DEF      = 8;

    // depths of the internal queues
    localparam int CMD_DEPTH = 4;
    localparam int RES_DEPTH = 4;

    // operation codes of an input word
    localparam logic [1:0] OP_ADMIT  = 2'd0;
    localparam logic [1:0] OP_FINISH = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // action codes of a result word
    localparam logic [1:0] ACT_STOP   = 2'd0;
    localparam logic [1:0] ACT_LAUNCH = 2'd1;
    localparam logic [1:0] ACT_CONT   = 2'd2;

    // configuration register indexes
    localparam logic CFG_CPU_COUNT     = 1'b0;
    localparam logic CFG_PROCESS_COUNT = 1'b1;

    typedef struct packed {
        logic [1:0] operation;
        logic [5:0] process_id;
    } t_in_word;

    typedef struct packed {
        logic [1:0] action;
        logic [5:0] process_id_res;
        logic       last;
    } t_out_word;

    // classified command handed from front to back
    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] id;
    } t_cmd;

    typedef struct packed {
        logic [3:0] cpu_count;
        logic [6:0] process_count;
    } t_cfg;

    // process number lies inside the table
    function automatic logic id_in_range(input logic [5:0] id, input int max_n);
        return int'(id) < max_n;
    endfunction

endpackage

// File: sv/rrs_ram.sv
`timescale 1ns / 1ps

module rrs_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// File: sv/rrs_fifo.sv
`timescale 1ns / 1ps

module rrs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_rd;
    logic [PW-1:0]    r_wr;
    logic [CW-1:0]    r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: sv/rrs_front.sv
`timescale 1ns / 1ps

module rrs_front #(
    parameter int MAX_PROCESSES = rrs_pkg::MAX_PROCESSES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rrs_pkg::t_in_word i_in_word,
    output logic              o_full,
    input  logic              i_cmd_pop,
    output rrs_pkg::t_cmd     o_cmd,
    output logic              o_cmd_empty
);

    localparam int CMD_W = $bits(rrs_pkg::t_cmd);

    rrs_pkg::t_cmd    cmd;
    logic             keep;
    logic             q_full;
    logic [CMD_W-1:0] q_rdata;

    // classify: drop unknown operations and out-of-range process numbers
    always_comb begin
        cmd.kind = i_in_word.operation;
        cmd.id   = i_in_word.process_id;
        case (i_in_word.operation)
            rrs_pkg::OP_ADMIT,
            rrs_pkg::OP_FINISH: keep = rrs_pkg::id_in_range(i_in_word.process_id,
                                                            MAX_PROCESSES);
            rrs_pkg::OP_TICK:   keep = 1'b1;
            default:            keep = 1'b0;
        endcase
    end

    assign o_full = q_full;
    assign o_cmd  = rrs_pkg::t_cmd'(q_rdata);

    // command queue toward the back part
    rrs_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (rrs_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && !q_full && keep),
        .i_wdata (CMD_W'(cmd)),
        .o_full  (q_full),
        .i_pop   (i_cmd_pop),
        .o_rdata (q_rdata),
        .o_empty (o_cmd_empty)
    );

endmodule

// File: sv/rrs_back.sv
`timescale 1ns / 1ps

module rrs_back #(
    parameter int MAX_PROCESSES = rrs_pkg::MAX_PROCESSES_DEF,
    parameter int MAX_CPUS      = rrs_pkg::MAX_CPUS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rrs_pkg::t_cfg      i_cfg,
    input  rrs_pkg::t_cmd      i_cmd,
    input  logic               i_cmd_empty,
    output logic               o_cmd_pop,
    output logic               o_res_push,
    output rrs_pkg::t_out_word o_res_word,
    input  logic               i_res_full
);

    localparam int D   = MAX_PROCESSES;
    localparam int AW  = $clog2(D);
    localparam int LW  = $clog2(D + 1);
    localparam int FN  = (D < 64) ? D : 64;
    localparam int FW  = $clog2(FN);
    localparam int CW  = $clog2(MAX_CPUS + 1);
    localparam int RIW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_STOP  = 2'd1;
    localparam logic [1:0] S_LREQ  = 2'd2;
    localparam logic [1:0] S_LDATA = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [LW-1:0] r_level, n_level;
    logic [6:0]    r_total, n_total;
    logic [FN-1:0] r_fflag, n_fflag;
    logic [FN-1:0] r_sflag, n_sflag;
    logic [5:0]    r_run [MAX_CPUS];
    logic [5:0]    n_run [MAX_CPUS];
    logic [CW-1:0] r_rlevel, n_rlevel;
    logic [CW-1:0] r_ridx, n_ridx;
    logic [CW-1:0] r_lcnt, n_lcnt;

    logic          ram_we;
    logic [5:0]    ram_wdata;
    logic          ram_re;
    logic [5:0]    ram_rdata;
    logic [CW-1:0] slots;
    logic          level_ok;
    logic [5:0]    stop_p;
    logic          stop_fin;
    logic          will_launch;
    logic          more;
    logic          fresh;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(D - 1)) ? '0 : p + 1'b1;
    endfunction

    // waiting queue storage
    rrs_ram #(
        .WIDTH (6),
        .DEPTH (D)
    ) u_wait_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_tail),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    // processors in use this slice, clipped to the hardware limit
    always_comb begin
        if (int'(i_cfg.cpu_count) > MAX_CPUS) begin
            slots = CW'(MAX_CPUS);
        end else begin
            slots = CW'(i_cfg.cpu_count);
        end
    end

    assign level_ok = (r_level != LW'(D));
    assign stop_p   = r_run[r_ridx[RIW-1:0]];
    assign stop_fin = rrs_pkg::id_in_range(stop_p, D) && r_fflag[stop_p[FW-1:0]];

    // command execution sequencer
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_level     = r_level;
        n_total     = r_total;
        n_fflag     = r_fflag;
        n_sflag     = r_sflag;
        n_run       = r_run;
        n_rlevel    = r_rlevel;
        n_ridx      = r_ridx;
        n_lcnt      = r_lcnt;
        o_cmd_pop   = 1'b0;
        ram_we      = 1'b0;
        ram_wdata   = i_cmd.id;
        ram_re      = 1'b0;
        o_res_push  = 1'b0;
        o_res_word  = '0;
        will_launch = 1'b0;
        more        = 1'b0;
        fresh       = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.kind)
                        rrs_pkg::OP_ADMIT: begin
                            if (level_ok) begin
                                ram_we  = 1'b1;
                                n_tail  = ptr_inc(r_tail);
                                n_level = r_level + 1'b1;
                            end
                        end
                        rrs_pkg::OP_FINISH: begin
                            n_fflag[i_cmd.id[FW-1:0]] = 1'b1;
                        end
                        rrs_pkg::OP_TICK: begin
                            if (r_total != i_cfg.process_count) begin
                                if (r_rlevel != '0) begin
                                    n_ridx  = '0;
                                    n_state = S_STOP;
                                end else begin
                                    n_state = S_LREQ;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // one stop per cycle while the result queue has room, in running order
            S_STOP: begin
                if (!i_res_full) begin
                    o_res_push                = 1'b1;
                    o_res_word.action         = rrs_pkg::ACT_STOP;
                    o_res_word.process_id_res = stop_p;
                    if (stop_fin) begin
                        if (r_total != 7'h7f) begin
                            n_total = r_total + 1'b1;
                        end
                    end else if (level_ok) begin
                        ram_we    = 1'b1;
                        ram_wdata = stop_p;
                        n_tail    = ptr_inc(r_tail);
                        n_level   = r_level + 1'b1;
                    end
                    if (r_ridx == r_rlevel - 1'b1) begin
                        n_rlevel        = '0;
                        will_launch     = (slots != '0) && (n_level != '0);
                        o_res_word.last = !will_launch;
                        n_state         = will_launch ? S_LREQ : S_IDLE;
                    end else begin
                        n_ridx = r_ridx + 1'b1;
                    end
                end
            end
            // first read from the waiting queue
            S_LREQ: begin
                if ((slots != '0) && (r_level != '0)) begin
                    ram_re  = 1'b1;
                    n_head  = ptr_inc(r_head);
                    n_level = r_level - 1'b1;
                    n_lcnt  = '0;
                    n_state = S_LDATA;
                end else begin
                    n_state = S_IDLE;
                end
            end
            // one launch or continue per cycle while the result queue has room, next read overlapped
            S_LDATA: begin
                if (!i_res_full) begin
                    fresh = rrs_pkg::id_in_range(ram_rdata, D) &&
                            !r_sflag[ram_rdata[FW-1:0]];
                    if (fresh) begin
                        n_sflag[ram_rdata[FW-1:0]] = 1'b1;
                    end
                    o_res_push                = 1'b1;
                    o_res_word.action         = fresh ? rrs_pkg::ACT_LAUNCH
                                                      : rrs_pkg::ACT_CONT;
                    o_res_word.process_id_res = ram_rdata;
                    n_run[r_rlevel[RIW-1:0]]  = ram_rdata;
                    n_rlevel                  = r_rlevel + 1'b1;
                    n_lcnt                    = r_lcnt + 1'b1;
                    more                      = (n_lcnt < slots) && (r_level != '0);
                    o_res_word.last           = !more;
                    if (more) begin
                        ram_re  = 1'b1;
                        n_head  = ptr_inc(r_head);
                        n_level = r_level - 1'b1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // running list entries
    always_ff @(posedge i_clk) begin
        r_run <= n_run;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_level  <= '0;
            r_total  <= '0;
            r_fflag  <= '0;
            r_sflag  <= '0;
            r_rlevel <= '0;
            r_ridx   <= '0;
            r_lcnt   <= '0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_level  <= n_level;
            r_total  <= n_total;
            r_fflag  <= n_fflag;
            r_sflag  <= n_sflag;
            r_rlevel <= n_rlevel;
            r_ridx   <= n_ridx;
            r_lcnt   <= n_lcnt;
        end
    end

    // waiting queue never overfills
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LW'(D))
        else $error("waiting level above depth");

    // running list never holds more than the processors
    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rlevel <= CW'(MAX_CPUS))
        else $error("running level above processor count");

    // a pop only from a non-empty waiting queue
    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |-> (r_level != '0))
        else $error("read from empty waiting queue");

    // launch data always follows a read or a stalled cycle in that state
    a_ldata_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LDATA) |-> ($past(ram_re) || $past(r_state == S_LDATA)))
        else $error("launch without a waiting queue read");

endmodule

// File: sv/multi_cpu_round_robin_scheduler.sv
`timescale 1ns / 1ps

// Round-robin time-slice scheduler for several processors.
// Input channel (push/full): words carry an operation and a process number.
//   Admit queues the process, finished marks it done, a tick ends a slice.
//   Admits and finished words are absorbed with no result.
// Result channel (empty/pop): words carry an action (stop, launch, continue),
//   the process number and a last flag set on the final word of a tick.
// Configuration: i_cfg_we writes register i_cfg_idx (0 processor count,
//   1 process count) with i_cfg_data; no wait, no read-back.
// The back sequencer produces one stop or launch word per cycle while the result
//   queue has room, and each launch is read from the waiting queue RAM ahead of
//   its word.
// Admit and finished words are handled in the idle state. A small command queue sits
//   in front, so new words are taken while a tick is still being worked off.
// When the result side stalls, the result queue fills, the sequencer holds,
//   then the command queue fills and full is raised.
// Reset (synchronous, active low) empties all queues, clears the started and
//   finished flags and the finished total, sets processor count 1, process
//   count 0; there is no clearing pass.
module multi_cpu_round_robin_scheduler #(
    parameter int MAX_PROCESSES = rrs_pkg::MAX_PROCESSES_DEF,
    parameter int MAX_CPUS      = rrs_pkg::MAX_CPUS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    input  rrs_pkg::t_in_word  i_in_word,
    output logic               full,
    output logic               empty,
    input  logic               pop,
    output rrs_pkg::t_out_word o_out_word,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [6:0]         i_cfg_data
);

    localparam int RES_W = $bits(rrs_pkg::t_out_word);

    rrs_pkg::t_cfg      r_cfg;
    rrs_pkg::t_cmd      cmd;
    logic               cmd_empty;
    logic               cmd_pop;
    logic               res_push;
    rrs_pkg::t_out_word res_word;
    logic               res_full;
    logic [RES_W-1:0]   res_rdata;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cpu_count     <= 4'd1;
            r_cfg.process_count <= 7'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rrs_pkg::CFG_CPU_COUNT:     r_cfg.cpu_count     <= i_cfg_data[3:0];
                rrs_pkg::CFG_PROCESS_COUNT: r_cfg.process_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: accept and classify
    rrs_front #(
        .MAX_PROCESSES (MAX_PROCESSES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_in_word   (i_in_word),
        .o_full      (full),
        .i_cmd_pop   (cmd_pop),
        .o_cmd       (cmd),
        .o_cmd_empty (cmd_empty)
    );

    // back: queues and slice sequencing
    rrs_back #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .MAX_CPUS      (MAX_CPUS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_res_push  (res_push),
        .o_res_word  (res_word),
        .i_res_full  (res_full)
    );

    // result queue
    rrs_fifo #(
        .WIDTH (RES_W),
        .DEPTH (rrs_pkg::RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (RES_W'(res_word)),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_rdata (res_rdata),
        .o_empty (empty)
    );

    assign o_out_word = rrs_pkg::t_out_word'(res_rdata);

endmodule

// File: tb/sv/multi_cpu_round_robin_scheduler_chk.sv
`timescale 1ns / 1ps

module multi_cpu_round_robin_scheduler_chk #(
    parameter int MAX_PROCESSES = rrs_pkg::MAX_PROCESSES_DEF,
    parameter int MAX_CPUS      = rrs_pkg::MAX_CPUS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_full,
    input  rrs_pkg::t_in_word  i_in_word,
    input  logic               i_empty,
    input  logic               i_pop,
    input  rrs_pkg::t_out_word i_out_word,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [6:0]         i_cfg_data,
    output int                 o_fails,
    output int                 o_pending,
    output int                 o_checked
);

    localparam int PRINT_CAP = 30;

    // shadow of the scheduler state
    logic [3:0]               cpu_cnt;
    logic [6:0]               proc_cnt;
    logic [5:0]               ready_q[$];
    logic [5:0]               run_q[$];
    logic [MAX_PROCESSES-1:0] started_mask;
    logic [MAX_PROCESSES-1:0] done_mask;
    logic [6:0]               done_total;

    // actions still owed by the block, oldest first
    rrs_pkg::t_out_word action_q[$];
    int                 fails   = 0;
    int                 checked = 0;

    // end of a time slice: stop everything running, then refill the processors
    task automatic tick_slice();
        logic [5:0]         p;
        int                 slots;
        int                 base;
        rrs_pkg::t_out_word w;
        if (done_total == proc_cnt)
            return;
        base = action_q.size();
        foreach (run_q[i]) begin
            p = run_q[i];
            w.action         = rrs_pkg::ACT_STOP;
            w.process_id_res = p;
            w.last           = 1'b0;
            action_q.push_back(w);
            if (int'(p) < MAX_PROCESSES && done_mask[p]) begin
                // finished count saturates
                if (done_total != 7'd127)
                    done_total = done_total + 7'd1;
            end else if (ready_q.size() < MAX_PROCESSES) begin
                ready_q.push_back(p);
            end
        end
        run_q.delete();
        slots = int'(cpu_cnt);
        if (slots > MAX_CPUS)
            slots = MAX_CPUS;
        for (int i = 0; i < slots && ready_q.size() > 0; i++) begin
            p = ready_q.pop_front();
            w.action = rrs_pkg::ACT_CONT;
            if (int'(p) < MAX_PROCESSES && !started_mask[p]) begin
                started_mask[p] = 1'b1;
                w.action = rrs_pkg::ACT_LAUNCH;
            end
            w.process_id_res = p;
            w.last           = 1'b0;
            run_q.push_back(p);
            action_q.push_back(w);
        end
        // flag the final word of this tick
        if (action_q.size() > base) begin
            w = action_q.pop_back();
            w.last = 1'b1;
            action_q.push_back(w);
        end
    endtask

    task automatic take_word(input rrs_pkg::t_in_word w);
        case (w.operation)
            rrs_pkg::OP_ADMIT: begin
                if (int'(w.process_id) < MAX_PROCESSES && ready_q.size() < MAX_PROCESSES)
                    ready_q.push_back(w.process_id);
            end
            rrs_pkg::OP_FINISH: begin
                if (int'(w.process_id) < MAX_PROCESSES)
                    done_mask[w.process_id] = 1'b1;
            end
            rrs_pkg::OP_TICK: tick_slice();
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            fails++;
            if (fails <= PRINT_CAP)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic check_word(input rrs_pkg::t_out_word got);
        rrs_pkg::t_out_word want;
        checked++;
        if (action_q.size() == 0) begin
            fails++;
            if (fails <= PRINT_CAP)
                $display("%0t: unexpected word, expected none, actual act %0d pid %0d last %0b",
                         $time, got.action, got.process_id_res, got.last);
        end else begin
            want = action_q.pop_front();
            check_field("action", 8'(want.action), 8'(got.action));
            check_field("process_id_res", 8'(want.process_id_res), 8'(got.process_id_res));
            check_field("last", 8'(want.last), 8'(got.last));
        end
    endtask

    // watch both channels and the register port
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cpu_cnt      = 4'd1;
            proc_cnt     = 7'd0;
            started_mask = '0;
            done_mask    = '0;
            done_total   = 7'd0;
            ready_q.delete();
            run_q.delete();
            action_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rrs_pkg::CFG_CPU_COUNT:     cpu_cnt  = i_cfg_data[3:0];
                    rrs_pkg::CFG_PROCESS_COUNT: proc_cnt = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_push && !i_full)
                take_word(i_in_word);
            if (i_pop && !i_empty)
                check_word(i_out_word);
        end
        o_pending <= action_q.size();
        o_fails   <= fails;
        o_checked <= checked;
    end

endmodule

// File: tb/sv/multi_cpu_round_robin_scheduler_tb.sv
`timescale 1ns / 1ps

module multi_cpu_round_robin_scheduler_tb;

    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         SETTLE_CYCLES  = 24;
    localparam int         TAIL_CYCLES    = 40;
    localparam int         RAND_PHASES    = 6;
    localparam int         PHASE_ITEMS    = 12;
    localparam int         DEEP_ROUNDS    = 2;
    localparam int         FLUSH_TICKS    = 4;
    localparam logic [1:0] OP_UNUSED      = 2'd3;
    // marked finished early on, reused to fill the waiting queue
    localparam logic [5:0] DONE_PID       = 6'd63;

    logic               i_clk;
    logic               i_rst_n  = 1'b0;
    logic               push     = 1'b0;
    rrs_pkg::t_in_word  in_word  = '0;
    logic               full;
    logic               empty;
    logic               pop      = 1'b0;
    rrs_pkg::t_out_word out_word;
    logic               cfg_we   = 1'b0;
    logic               cfg_idx  = 1'b0;
    logic [6:0]         cfg_data = 7'd0;
    logic               idle_on  = 1'b1;

    int fails;
    int pending;
    int checked;
    int sent_cnt     = 0;
    int tick_cnt     = 0;
    int cfg_cnt      = 0;
    int pop_hold     = 0;
    int quiet_cycles = 0;

    logic [63:0] marked_done = '0;

    multi_cpu_round_robin_scheduler dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .i_in_word  (in_word),
        .full       (full),
        .empty      (empty),
        .pop        (pop),
        .o_out_word (out_word),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    multi_cpu_round_robin_scheduler_chk chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_full     (full),
        .i_in_word  (in_word),
        .i_empty    (empty),
        .i_pop      (pop),
        .i_out_word (out_word),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_fails    (fails),
        .o_pending  (pending),
        .o_checked  (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // result side: pop with random stall bursts
    always @(posedge i_clk) begin
        if (pop_hold > 0) begin
            pop_hold <= pop_hold - 1;
            pop      <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            pop_hold <= $urandom_range(0, 2);
            pop      <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one word, with an optional gap first, and hold it until taken
    task automatic send_word(input logic [1:0] op, input logic [5:0] pid);
        rrs_pkg::t_in_word w;
        int                gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        w.operation  = op;
        w.process_id = pid;
        push    <= 1'b1;
        in_word <= w;
        do @(posedge i_clk); while (full);
        if (op != OP_UNUSED)
            sent_cnt++;
        if (op == rrs_pkg::OP_TICK)
            tick_cnt++;
        if (op == rrs_pkg::OP_FINISH)
            marked_done[pid] = 1'b1;
    endtask

    // hold off until every owed action has come back
    task automatic drain();
        push <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // both registers, only with the block idle
    task automatic write_config(input logic [3:0] cpus, input logic [6:0] procs);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= rrs_pkg::CFG_CPU_COUNT;
        cfg_data <= {3'd0, cpus};
        @(posedge i_clk);
        cfg_idx  <= rrs_pkg::CFG_PROCESS_COUNT;
        cfg_data <= procs;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        cfg_cnt++;
    endtask

    // mostly admits and ticks, some finishes, a few unused codes
    task automatic rand_item();
        int         r;
        logic [1:0] op;
        logic [5:0] pid;
        r   = $urandom_range(0, 99);
        pid = $urandom_range(0, 63);
        if (r < 48)
            op = rrs_pkg::OP_ADMIT;
        else if (r < 62)
            op = rrs_pkg::OP_FINISH;
        else if (r < 96)
            op = rrs_pkg::OP_TICK;
        else
            op = OP_UNUSED;
        send_word(op, pid);
    endtask

    initial begin
        int         target;
        int         picked;
        logic [3:0] cpu_tab [RAND_PHASES];
        logic [6:0] proc_tab[RAND_PHASES];

        cpu_tab  = '{4'd8, 4'd1, 4'd3, 4'd15, 4'd4, 4'd6};
        proc_tab = '{7'd127, 7'd64, 7'd0, 7'd100, 7'd127, 7'd127};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // out of reset: process count zero equals finished total, tick is dead
        send_word(rrs_pkg::OP_TICK, 6'd0);
        send_word(OP_UNUSED, 6'h3f);
        send_word(rrs_pkg::OP_ADMIT, DONE_PID);

        // one processor, one process: launch, finish, drop, then go quiet
        write_config(4'd1, 7'd1);
        send_word(rrs_pkg::OP_TICK, 6'h15);
        send_word(rrs_pkg::OP_FINISH, DONE_PID);
        send_word(rrs_pkg::OP_TICK, 6'h2a);
        send_word(rrs_pkg::OP_TICK, 6'h3f);

        // empty tick, then zero processors with work waiting
        write_config(4'd0, 7'd127);
        send_word(rrs_pkg::OP_TICK, 6'd0);
        send_word(rrs_pkg::OP_ADMIT, 6'd0);
        send_word(rrs_pkg::OP_ADMIT, 6'd0);
        send_word(rrs_pkg::OP_TICK, 6'd0);

        // count above the processor limit, repeats, re-admit of a finished number
        write_config(4'd15, 7'd127);
        send_word(rrs_pkg::OP_ADMIT, 6'h2a);
        send_word(rrs_pkg::OP_ADMIT, 6'h15);
        send_word(rrs_pkg::OP_TICK, 6'd0);
        send_word(rrs_pkg::OP_TICK, 6'd0);
        send_word(rrs_pkg::OP_FINISH, 6'h2a);
        send_word(rrs_pkg::OP_ADMIT, DONE_PID);
        send_word(rrs_pkg::OP_TICK, 6'd0);
        send_word(rrs_pkg::OP_TICK, 6'd0);

        // random phases over several settings
        for (int k = 0; k < RAND_PHASES; k++) begin
            if (k == 4)
                write_config(4'($urandom_range(1, 8)), 7'($urandom_range(0, 127)));
            else
                write_config(cpu_tab[k], proc_tab[k]);
            idle_on <= (k != 2);
            target = sent_cnt + PHASE_ITEMS;
            while (sent_cnt < target) begin
                rand_item();
                if (k == 3 && sent_cnt == target - PHASE_ITEMS / 2)
                    drain();
            end
        end

        // full waiting queue and stops into it, no idling from here on
        write_config(4'd8, 7'd0);
        idle_on <= 1'b0;
        send_word(rrs_pkg::OP_FINISH, DONE_PID);
        picked = 0;
        for (int p = 0; p < 63 && picked < 8; p++) begin
            if (!marked_done[p]) begin
                send_word(rrs_pkg::OP_ADMIT, 6'(p));
                picked++;
            end
        end
        repeat (60) send_word(rrs_pkg::OP_ADMIT, DONE_PID);
        for (int r = 0; r < DEEP_ROUNDS; r++) begin
            send_word(rrs_pkg::OP_TICK, 6'($urandom_range(0, 63)));
            repeat (8) send_word(rrs_pkg::OP_ADMIT, DONE_PID);
        end
        repeat (FLUSH_TICKS) send_word(rrs_pkg::OP_TICK, 6'd0);

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run: %0d input words, %0d of them ticks, over %0d register settings",
                 sent_cnt, tick_cnt, cfg_cnt);
        $display("run: %0d result words compared, %0d mismatches", checked, fails);
        if (fails == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
